>>> rtl/aat_pkg.sv
// Shared types, constants and register map of the box transform block.
package aat_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_COORD_WIDTH = 32;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  // Coefficients and translations are signed Q16.16 halves of 64-bit registers.
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_AXES  = 3;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_X_XY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_ZO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_XY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ZO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_XY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_ZO = 3'd5;

  // Reset loads the identity transform.
  localparam logic [CFG_W-1:0] RST_X_XY = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] RST_X_ZO = 64'h0;
  localparam logic [CFG_W-1:0] RST_Y_XY = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_Y_ZO = 64'h0;
  localparam logic [CFG_W-1:0] RST_Z_XY = 64'h0;
  localparam logic [CFG_W-1:0] RST_Z_ZO = 64'h0000_0000_0001_0000;

  // Load enables from the pipeline control to the lanes.
  typedef struct packed {
    logic prod;
    logic sum;
  } stage_en_t;

endpackage

>>> rtl/aat_lane.sv
// One output axis: operand select, six products, then the min and max sums.
module aat_lane import aat_pkg::*; #(
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                       clk_i,
  input  stage_en_t                                  en_i,
  input  logic [CFG_W-1:0]                           coef_xy_i,
  input  logic [CFG_W-1:0]                           coef_zo_i,
  input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]       bmin_i,
  input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]       bmax_i,
  output logic [COEF_W+COORD_WIDTH+2-1:0]            smin_o,
  output logic [COEF_W+COORD_WIDTH+2-1:0]            smax_o
);

  localparam int unsigned PROD_W = COEF_W + COORD_WIDTH;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic [NUM_AXES-1:0][COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_lo_d [NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi_d [NUM_AXES];
  logic signed [PROD_W-1:0] prod_lo_q [NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi_q [NUM_AXES];
  logic signed [SUM_W-1:0]  smin_d, smax_d, smin_q, smax_q;

  assign coef[0] = coef_xy_i[COEF_W-1:0];
  assign coef[1] = coef_xy_i[CFG_W-1:COEF_W];
  assign coef[2] = coef_zo_i[COEF_W-1:0];

  // A positive coefficient pairs min with min; zero or negative swaps the bounds.
  always_comb begin
    logic signed [COEF_W-1:0]      c;
    logic signed [COORD_WIDTH-1:0] op_lo;
    logic signed [COORD_WIDTH-1:0] op_hi;
    logic                          pos;
    for (int i = 0; i < NUM_AXES; i++) begin
      c     = coef[i];
      pos   = !c[COEF_W-1] && (|c);
      op_lo = pos ? bmin_i[i] : bmax_i[i];
      op_hi = pos ? bmax_i[i] : bmin_i[i];
      prod_lo_d[i] = c * op_lo;
      prod_hi_d[i] = c * op_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
    end
  end

  // Products drop their fraction toward minus infinity, then add onto the offset.
  always_comb begin
    logic signed [COEF_W-1:0] off;
    logic signed [PROD_W-1:0] sh_lo;
    logic signed [PROD_W-1:0] sh_hi;
    off    = coef_zo_i[CFG_W-1:COEF_W];
    smin_d = SUM_W'(off);
    smax_d = SUM_W'(off);
    for (int i = 0; i < NUM_AXES; i++) begin
      sh_lo  = prod_lo_q[i] >>> FRAC_BITS;
      sh_hi  = prod_hi_q[i] >>> FRAC_BITS;
      smin_d = smin_d + SUM_W'(sh_lo);
      smax_d = smax_d + SUM_W'(sh_hi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      smin_q <= smin_d;
      smax_q <= smax_d;
    end
  end

  assign smin_o = smin_q;
  assign smax_o = smax_q;

endmodule

>>> rtl/aat_merge.sv
// Output stage: clamps the lane sums, gathers the overflow flag, holds the item.
module aat_merge import aat_pkg::*; #(
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              sum_vld_i,
  output logic                                              sum_ready_o,
  input  logic [NUM_AXES-1:0][COEF_W+COORD_WIDTH+2-1:0]     smin_i,
  input  logic [NUM_AXES-1:0][COEF_W+COORD_WIDTH+2-1:0]     smax_i,
  output logic                                              out_vld_o,
  input  logic                                              out_ready_i,
  output logic [2*NUM_AXES-1:0][COORD_WIDTH-1:0]            bounds_o,
  output logic                                              sat_o
);

  localparam int unsigned SUM_W = COEF_W + COORD_WIDTH + 2;
  localparam int unsigned EXT_W = SUM_W - COORD_WIDTH + 1;

  localparam logic signed [SUM_W-1:0] SUM_HI =
    {{EXT_W{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO =
    {{EXT_W{1'b1}}, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] OUT_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] OUT_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                                       vld_q;
  logic [2*NUM_AXES-1:0][COORD_WIDTH-1:0]     bounds_d, bounds_q;
  logic                                       sat_d, sat_q;

  always_comb begin
    logic signed [SUM_W-1:0] s;
    sat_d = 1'b0;
    for (int b = 0; b < 2*NUM_AXES; b++) begin
      s = (b < NUM_AXES) ? smin_i[b % NUM_AXES] : smax_i[b % NUM_AXES];
      if (s > SUM_HI) begin
        bounds_d[b] = OUT_HI;
        sat_d       = 1'b1;
      end else if (s < SUM_LO) begin
        bounds_d[b] = OUT_LO;
        sat_d       = 1'b1;
      end else begin
        bounds_d[b] = s[COORD_WIDTH-1:0];
      end
    end
  end

  assign sum_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (sum_ready_o) begin
      vld_q <= sum_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready_o && sum_vld_i) begin
      bounds_q <= bounds_d;
      sat_q    <= sat_d;
    end
  end

  assign out_vld_o = vld_q;
  assign bounds_o  = bounds_q;
  assign sat_o     = sat_q;

endmodule

>>> rtl/aabb_affine_transform.sv
// Top level: config registers, three axis lanes and the output merge stage.
// m_axis_tvalid_o rises once an accepted box has passed three register stages
// (products at the accept edge, then sums, then output). Throughput: one box per
// cycle unless stalled; each lane has six multipliers, one per product.
// Each stage holds its item while the next is full, so back-pressure stalls in place.
// Reset (rst_ni low, async) empties the pipeline and loads the identity transform.
// Config writes take effect at once and are meant for an idle pipeline only.
module aabb_affine_transform import aat_pkg::*; #(
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // Config write port
  input  logic                                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                          cfg_idx_i,
  input  logic [CFG_W-1:0]                              cfg_data_i,
  // Input boxes
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // tdata: min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]            s_axis_tdata_i,
  // Output boxes
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  // tdata: out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z, zero pad
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]            m_axis_tdata_o,
  // tuser: saturated
  output logic                                          m_axis_tuser_o
);

  localparam int unsigned BOX_W   = 2 * NUM_AXES * COORD_WIDTH;
  localparam int unsigned TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned SUM_W   = COEF_W + COORD_WIDTH + 2;

  logic [CFG_W-1:0] cfg_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_X_XY] <= RST_X_XY;
      cfg_q[REG_X_ZO] <= RST_X_ZO;
      cfg_q[REG_Y_XY] <= RST_Y_XY;
      cfg_q[REG_Y_ZO] <= RST_Y_ZO;
      cfg_q[REG_Z_XY] <= RST_Z_XY;
      cfg_q[REG_Z_ZO] <= RST_Z_ZO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_XY: cfg_q[REG_X_XY] <= cfg_data_i;
        REG_X_ZO: cfg_q[REG_X_ZO] <= cfg_data_i;
        REG_Y_XY: cfg_q[REG_Y_XY] <= cfg_data_i;
        REG_Y_ZO: cfg_q[REG_Y_ZO] <= cfg_data_i;
        REG_Z_XY: cfg_q[REG_Z_XY] <= cfg_data_i;
        REG_Z_ZO: cfg_q[REG_Z_ZO] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic      prod_vld_q, sum_vld_q;
  logic      sum_ready, merge_ready;
  stage_en_t en;

  assign sum_ready       = !sum_vld_q || merge_ready;
  assign s_axis_tready_o = !prod_vld_q || sum_ready;
  assign en.prod         = s_axis_tvalid_i && s_axis_tready_o;
  assign en.sum          = sum_ready && prod_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
    end else begin
      if (s_axis_tready_o) prod_vld_q <= s_axis_tvalid_i;
      if (sum_ready)       sum_vld_q  <= prod_vld_q;
    end
  end

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] bmin, bmax;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      bmin[i] = s_axis_tdata_i[i*COORD_WIDTH +: COORD_WIDTH];
      bmax[i] = s_axis_tdata_i[(i+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  logic [NUM_AXES-1:0][SUM_W-1:0] smin, smax;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    aat_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .coef_xy_i (cfg_q[2*g]),
      .coef_zo_i (cfg_q[2*g+1]),
      .bmin_i    (bmin),
      .bmax_i    (bmax),
      .smin_o    (smin[g]),
      .smax_o    (smax[g])
    );
  end

  logic [2*NUM_AXES-1:0][COORD_WIDTH-1:0] bounds;

  aat_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_vld_i   (sum_vld_q),
    .sum_ready_o (merge_ready),
    .smin_i      (smin),
    .smax_i      (smax),
    .out_vld_o   (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .bounds_o    (bounds),
    .sat_o       (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = TDATA_W'(BOX_W'(bounds));

  // Some bound sits on a rail whenever the overflow flag is up.
  localparam logic [COORD_WIDTH-1:0] RAIL_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] RAIL_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  logic out_at_rail;

  always_comb begin
    out_at_rail = 1'b0;
    for (int b = 0; b < 2*NUM_AXES; b++) begin
      if (bounds[b] == RAIL_HI || bounds[b] == RAIL_LO) out_at_rail = 1'b1;
    end
  end

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> prod_vld_q)
    else $error("accepted item did not reach the product stage");

  a_prod_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q && !sum_ready |=> prod_vld_q)
    else $error("stalled product stage lost its item");

  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_vld_q && !merge_ready |=> sum_vld_q)
    else $error("stalled sum stage lost its item");

  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> out_at_rail)
    else $error("saturated flag set with no bound clamped");

endmodule

>>> bench/aabb_affine_transform_tb.sv
// Self-checking bench for the box transform block: directed boxes, random boxes, transform sweeps.
`timescale 1ns / 1ps

module aabb_affine_transform_tb;
  import aat_pkg::*;

  localparam int CW         = DEF_COORD_WIDTH;
  localparam int FB         = DEF_FRAC_BITS;
  localparam int TD_W       = ((6 * CW + 7) / 8) * 8;
  localparam int CLK_HALF   = 10;
  localparam int PIPE_LAT   = 3;
  localparam int NUM_PHASES = 9;
  localparam int RAND_ITEMS = 110;
  localparam int HOLD_TICKS = 64;
  localparam int MAX_PRINTS = 100;

  // Indexes past the register map; writes there must leave the transform alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(NUM_REGS + 1);

  typedef logic signed [CW-1:0] coord_t;
  localparam coord_t C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t C_ONE = coord_t'(1) <<< FB;
  localparam longint SUM_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // Same layout as tdata: min_x in the lowest bits, max_z in the highest.
  typedef struct packed {
    coord_t [NUM_AXES-1:0] max_b;
    coord_t [NUM_AXES-1:0] min_b;
  } box_t;

  typedef struct {
    box_t b;
    logic sat;
  } aabb_res_t;

  typedef struct {
    box_t      box;
    bit        has_exp;
    box_t      exp_box;
    logic      exp_sat;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  // tdata: min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  logic [TD_W-1:0]   s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  // tdata: out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z, zero pad
  logic [TD_W-1:0]   m_axis_tdata_o;
  // tuser: saturated
  logic              m_axis_tuser_o;

  logic [CFG_W-1:0]  xform_regs [NUM_REGS];
  aabb_res_t         pending_boxes [$];
  dir_row_t          dir_rows [10];
  int unsigned       error_count;
  int unsigned       out_count;
  bit                src_gaps;
  bit                calm;
  bit                hold_off;
  string             axis_name [NUM_AXES] = '{"x", "y", "z"};
  aabb_res_t         want;
  box_t              got;

  aabb_affine_transform i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_HALF);
    clk_i = 1'b0;
    #(CLK_HALF);
  end

  // Coefficient times bound, exact, then floored to the fixed-point grid.
  function automatic longint scaled(longint c, coord_t v);
    return (c * longint'(v)) >>> FB;
  endfunction

  function automatic coord_t clamp_coord(longint v, inout logic flag);
    if (v > SUM_MAX) begin
      flag = 1'b1;
      return C_MAX;
    end
    if (v < SUM_MIN) begin
      flag = 1'b1;
      return C_MIN;
    end
    return coord_t'(v);
  endfunction

  // Enclosing box of the transformed input box under the current transform.
  function automatic aabb_res_t transform_box(box_t b);
    aabb_res_t        r;
    longint           acc_lo;
    longint           acc_hi;
    longint           c;
    logic [CFG_W-1:0] row_xy;
    logic [CFG_W-1:0] row_zo;
    r.sat = 1'b0;
    for (int o = 0; o < NUM_AXES; o++) begin
      row_xy = xform_regs[2 * o];
      row_zo = xform_regs[2 * o + 1];
      acc_lo = longint'(signed'(row_zo[2*COEF_W-1:COEF_W]));
      acc_hi = acc_lo;
      for (int i = 0; i < NUM_AXES; i++) begin
        c = longint'(signed'(i == 0 ? row_xy[COEF_W-1:0] :
                             i == 1 ? row_xy[2*COEF_W-1:COEF_W] : row_zo[COEF_W-1:0]));
        // zero takes the swapped branch too; both products vanish anyway
        if (c > 0) begin
          acc_lo += scaled(c, b.min_b[i]);
          acc_hi += scaled(c, b.max_b[i]);
        end else begin
          acc_lo += scaled(c, b.max_b[i]);
          acc_hi += scaled(c, b.min_b[i]);
        end
      end
      r.b.min_b[o] = clamp_coord(acc_lo, r.sat);
      r.b.max_b[o] = clamp_coord(acc_hi, r.sat);
    end
    return r;
  endfunction

  function automatic box_t mk_box(input coord_t lx, ly, lz, ux, uy, uz);
    box_t b;
    b.min_b[0] = lx;
    b.min_b[1] = ly;
    b.min_b[2] = lz;
    b.max_b[0] = ux;
    b.max_b[1] = uy;
    b.max_b[2] = uz;
    return b;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0, 1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'($urandom_range(0, 1 << 24)) - coord_t'(1 << 23);
    endcase
  endfunction

  // Mostly well-ordered boxes; about one axis in ten comes out inverted.
  function automatic box_t rand_box();
    box_t   b;
    coord_t u;
    coord_t v;
    for (int a = 0; a < NUM_AXES; a++) begin
      u = rand_coord();
      v = rand_coord();
      if (($urandom_range(0, 9) != 0) == (u > v)) begin
        b.min_b[a] = v;
        b.max_b[a] = u;
      end else begin
        b.min_b[a] = u;
        b.max_b[a] = v;
      end
    end
    return b;
  endfunction

  function automatic logic [COEF_W-1:0] rand_half();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx < NUM_REGS) xform_regs[idx] = val;
    @(negedge clk_i);
  endtask

  task automatic load_transform(input logic [CFG_W-1:0] regs [NUM_REGS], input bit poke_spare);
    for (int k = 0; k < NUM_REGS; k++) write_reg(CFG_IDX_W'(k), regs[k]);
    if (poke_spare) begin
      write_reg(REG_SPARE_A, {$urandom, $urandom});
      write_reg(REG_SPARE_B, {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_box(input box_t b, input aabb_res_t res);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TD_W'(b);
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_boxes.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic run_table(input bit use_typed);
    aabb_res_t res;
    foreach (dir_rows[r]) begin
      if (use_typed && dir_rows[r].has_exp) begin
        res.b   = dir_rows[r].exp_box;
        res.sat = dir_rows[r].exp_sat;
      end else begin
        res = transform_box(dir_rows[r].box);
      end
      send_box(dir_rows[r].box, res);
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 1) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch($sformatf("item %0d: output with nothing expected", out_count));
      end else begin
        want = pending_boxes.pop_front();
        got  = m_axis_tdata_o[6*CW-1:0];
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got.min_b[a] !== want.b.min_b[a])
            report_mismatch($sformatf("item %0d: min_%s got %h want %h", out_count,
                                      axis_name[a], got.min_b[a], want.b.min_b[a]));
          if (got.max_b[a] !== want.b.max_b[a])
            report_mismatch($sformatf("item %0d: max_%s got %h want %h", out_count,
                                      axis_name[a], got.max_b[a], want.b.max_b[a]));
        end
        if (m_axis_tuser_o !== want.sat)
          report_mismatch($sformatf("item %0d: saturated got %b want %b", out_count,
                                    m_axis_tuser_o, want.sat));
      end
      out_count++;
    end
  end

  // Sink side: ready runs, short stalls, and one long hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off && !calm) begin
        m_axis_tready_i <= 1'b0;
        for (int n = 0; n < HOLD_TICKS; n++) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #(2 * CLK_HALF * 400_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] next_regs [NUM_REGS];
    box_t             rnd_box;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    error_count     = 0;
    out_count       = 0;
    src_gaps        = 1'b1;
    calm            = 1'b0;
    hold_off        = 1'b0;
    xform_regs = '{RST_X_XY, RST_X_ZO, RST_Y_XY, RST_Y_ZO, RST_Z_XY, RST_Z_ZO};

    // Under the reset identity every box passes through unchanged.
    dir_rows = '{
      '{mk_box(0, 0, 0, 0, 0, 0), 1'b1, mk_box(0, 0, 0, 0, 0, 0), 1'b0},
      '{mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b1,
        mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b0},
      '{mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b1,
        mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b0},
      '{mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1,
        mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b0},
      // inverted box goes through the same formulas
      '{mk_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1'b1,
        mk_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1'b0},
      '{mk_box(-1, -1, -1, 1, 1, 1), 1'b0, '0, 1'b0},
      '{mk_box(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
               32'h5555_5555, 32'h5555_5555, 32'h5555_5555), 1'b0, '0, 1'b0},
      '{mk_box(-C_ONE, -2 * C_ONE, C_ONE / 2, C_ONE, 3 * C_ONE, C_ONE + C_ONE / 4),
        1'b0, '0, 1'b0},
      '{mk_box(3 * C_ONE, 3 * C_ONE, 3 * C_ONE, 3 * C_ONE, 3 * C_ONE, 3 * C_ONE),
        1'b0, '0, 1'b0},
      '{mk_box(-5 * C_ONE, 7, 0, -C_ONE, 9, C_MAX), 1'b0, '0, 1'b0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_table(1'b1);

    // Sweep: all-max, all-min, all-zero transforms, then random ones.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      for (int k = 0; k < NUM_REGS; k++) begin
        case (ph)
          0: next_regs[k] = {2{32'h7FFF_FFFF}};
          1: next_regs[k] = {2{32'h8000_0000}};
          2: next_regs[k] = '0;
          default: next_regs[k] = {rand_half(), rand_half()};
        endcase
      end
      load_transform(next_regs, ph == 3);
      calm     = (ph == NUM_PHASES - 1);
      src_gaps = !calm && ($urandom_range(0, 3) != 0);
      run_table(1'b0);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // stall the sink while the source pushes back to back
        if (ph == 4 && n == 10) begin
          src_gaps = 1'b0;
          hold_off = 1'b1;
        end
        rnd_box = rand_box();
        send_box(rnd_box, transform_box(rnd_box));
      end
      s_axis_tvalid_i <= 1'b0;
    end

    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT * 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
